### sv/stl_pkg.sv
package stl_pkg;

  // scanner modes
  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_COMMENT = 4'd1;
  localparam logic [3:0] M_IDENT   = 4'd2;
  localparam logic [3:0] M_NUMBER  = 4'd3;
  localparam logic [3:0] M_NUMDOT  = 4'd4;
  localparam logic [3:0] M_FLOAT   = 4'd5;
  localparam logic [3:0] M_STRING  = 4'd6;
  localparam logic [3:0] M_LESS    = 4'd7;
  localparam logic [3:0] M_DONE    = 4'd8;

  // token kinds
  localparam logic [4:0] K_PERIOD = 5'd8;
  localparam logic [4:0] K_LESS   = 5'd19;
  localparam logic [4:0] K_ARROW  = 5'd21;
  localparam logic [4:0] K_IDENT  = 5'd22;
  localparam logic [4:0] K_INT    = 5'd23;
  localparam logic [4:0] K_FLOAT  = 5'd24;
  localparam logic [4:0] K_STRING = 5'd25;
  localparam logic [4:0] K_END    = 5'd26;
  localparam logic [4:0] K_ERROR  = 5'd27;

  // error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_UNKNOWN    = 3'd1;
  localparam logic [2:0] ERR_TOO_LONG   = 3'd2;
  localparam logic [2:0] ERR_NL_STRING  = 3'd3;
  localparam logic [2:0] ERR_EOF_COMMENT = 3'd4;
  localparam logic [2:0] ERR_EOF_STRING = 3'd5;

  // characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_LESS  = 8'h3C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  localparam logic [6:0]  MAX_TOKEN_LEN = 7'd64;
  localparam logic [19:0] LINE_MAX = 20'hFFFFF;
  localparam logic [15:0] COL_MAX  = 16'hFFFF;
  localparam logic [62:0] VAL_MAX  = {63{1'b1}};

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [4:0]  kind;
    logic [23:0] off;
    logic [19:0] line;
    logic [15:0] col;
    logic [6:0]  len;
    logic [62:0] val;
    logic [2:0]  err;
    logic        last;
  } token_t;

  typedef struct packed {
    logic       ok;
    logic [4:0] kind;
  } punct_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c == 8'h5F) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  // single-byte punctuation; '<' is handled by the scanner
  function automatic punct_t punct_kind(input logic [7:0] c);
    punct_t p;
    p.ok = 1'b1;
    p.kind = 5'd0;
    case (c)
      8'h28: p.kind = 5'd0;
      8'h29: p.kind = 5'd1;
      8'h5B: p.kind = 5'd2;
      8'h5D: p.kind = 5'd3;
      8'h7B: p.kind = 5'd4;
      8'h7D: p.kind = 5'd5;
      8'h7C: p.kind = 5'd6;
      8'h3A: p.kind = 5'd7;
      8'h2E: p.kind = K_PERIOD;
      8'h2B: p.kind = 5'd9;
      8'h2D: p.kind = 5'd10;
      8'h2A: p.kind = 5'd11;
      8'h2F: p.kind = 5'd12;
      8'h25: p.kind = 5'd13;
      8'h21: p.kind = 5'd14;
      8'h7E: p.kind = 5'd15;
      8'h26: p.kind = 5'd16;
      8'h5E: p.kind = 5'd17;
      8'h3D: p.kind = 5'd18;
      8'h3E: p.kind = 5'd20;
      default: p.ok = 1'b0;
    endcase
    return p;
  endfunction

endpackage

### sv/source_token_lexer.sv
// Source token lexer. Takes one source byte per request on the slave stream
// (tuser high marks end of input, the byte is then ignored) and produces tokens
// on the master stream: tuser is the token kind, tdata carries start offset,
// line, column, length, integer value and error code, tlast marks the last
// token caused by one input request. Whitespace and double-quoted comments
// are skipped. A byte is taken while ready is high; its whole scanner update is
// done in the cycle it is accepted, and its tokens (at most three) go to a
// four-entry result queue. Ready is low while that queue has fewer than three
// free entries, so a steady stream with at most one token per byte runs at
// one byte per cycle; bytes giving several tokens or a stalled output slow it
// down. After the end token or an error the block swallows all input until reset.
// Write max_token_len (cfg_we_i / cfg_wdata_i) only while idle; the block won't check.
module source_token_lexer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [6:0]    cfg_wdata_i,      // max_token_len
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,     // in_byte
  input  logic          s_axis_tuser,     // end_of_input
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // start_offset[23:0], start_line[43:24], start_column[59:44],
  // token_length[66:60], int_value[129:67], error_code[132:130], zeros above
  output logic [135:0]  m_axis_tdata,
  output logic [4:0]    m_axis_tuser,     // token_kind
  output logic          m_axis_tlast      // last_of_run
);
  import stl_pkg::*;

  // scanner state
  logic [6:0]  max_len_q;
  logic [3:0]  mode_q, mode_d;
  logic [6:0]  tlen_q, tlen_d;
  logic [62:0] accum_q, accum_d;
  logic [23:0] pos_q, pos_d;
  logic [19:0] line_q, line_d;
  logic [15:0] col_q, col_d;
  logic [23:0] tso_q, tso_d;
  logic [19:0] tsl_q, tsl_d;
  logic [15:0] tsc_q, tsc_d;
  logic        halted_q, halted_d;

  // result queue
  token_t      queue_q [QUEUE_DEPTH];
  logic [1:0]  wr_ptr_q, rd_ptr_q;
  logic [2:0]  count_q;

  logic        s_fire, m_fire;
  logic [7:0]  c;
  logic [6:0]  limit;
  token_t      cand [4];
  logic [3:0]  cand_en;
  token_t      res [3];
  logic [1:0]  n_res;

  // step-local values
  logic        fresh;
  logic        fail_v;
  logic [2:0]  fail_code;
  logic        grow_ok1, grow_ok2;
  logic [16:0] dot_col;
  logic [66:0] acc_next;
  logic [3:0]  digit;
  punct_t      pk;

  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_fire = m_axis_tvalid && m_axis_tready;
  assign c      = s_axis_tdata;
  assign s_axis_tready = (count_q <= 3'd1);

  // effective length limit
  always_comb begin
    if (max_len_q == 7'd0) limit = 7'd1;
    else if (max_len_q > MAX_TOKEN_LEN) limit = MAX_TOKEN_LEN;
    else limit = max_len_q;
  end

  assign grow_ok1 = ({1'b0, tlen_q} + 8'd1) <= {1'b0, limit};
  assign grow_ok2 = ({1'b0, tlen_q} + 8'd2) <= {1'b0, limit};
  assign digit    = c[3:0] - 4'd0;
  assign acc_next = {1'b0, accum_q, 3'b0} + {3'b0, accum_q, 1'b0} + {63'd0, c[3:0]};
  assign dot_col  = {1'b0, tsc_q} + {10'd0, tlen_q};
  assign pk       = punct_kind(c);

  // one scanner step per accepted request
  always_comb begin
    mode_d   = mode_q;
    tlen_d   = tlen_q;
    accum_d  = accum_q;
    pos_d    = pos_q;
    line_d   = line_q;
    col_d    = col_q;
    tso_d    = tso_q;
    tsl_d    = tsl_q;
    tsc_d    = tsc_q;
    halted_d = halted_q;
    fresh    = 1'b0;
    fail_v   = 1'b0;
    fail_code = ERR_NONE;
    cand_en  = '0;
    for (int i = 0; i < 4; i++) cand[i] = '0;

    // slot 0: pending token, slot 1: period after int, slot 2: new byte or error,
    // slot 3: end token
    cand[0].kind = K_IDENT;
    cand[0].off  = tso_q;
    cand[0].line = tsl_q;
    cand[0].col  = tsc_q;
    cand[0].len  = tlen_q;
    cand[1].kind = K_PERIOD;
    cand[1].off  = tso_q + {17'd0, tlen_q};
    cand[1].line = tsl_q;
    cand[1].col  = dot_col[16] ? COL_MAX : dot_col[15:0];
    cand[1].len  = 7'd1;
    cand[2].off  = pos_q;
    cand[2].line = line_q;
    cand[2].col  = col_q;
    cand[3].kind = K_END;
    cand[3].off  = pos_q;
    cand[3].line = line_q;
    cand[3].col  = col_q;

    if (s_fire && !halted_q) begin
      if (s_axis_tuser) begin
        // end of input: flush pending token
        unique case (mode_q)
          M_COMMENT: begin
            fail_v = 1'b1;
            fail_code = ERR_EOF_COMMENT;
          end
          M_STRING: begin
            fail_v = 1'b1;
            fail_code = ERR_EOF_STRING;
          end
          M_IDENT: cand_en[0] = 1'b1;
          M_NUMBER: begin
            cand_en[0] = 1'b1;
            cand[0].kind = K_INT;
            cand[0].val = accum_q;
          end
          M_NUMDOT: begin
            cand_en[0] = 1'b1;
            cand[0].kind = K_INT;
            cand[0].val = accum_q;
            cand_en[1] = 1'b1;
          end
          M_FLOAT: begin
            cand_en[0] = 1'b1;
            cand[0].kind = K_FLOAT;
          end
          M_LESS: begin
            cand_en[0] = 1'b1;
            cand[0].kind = K_LESS;
            cand[0].len = 7'd1;
          end
          default: ;
        endcase
        cand_en[3] = !fail_v;
        halted_d = 1'b1;
        mode_d = M_DONE;
      end else begin
        unique case (mode_q)
          M_COMMENT: begin
            if (c == CH_QUOTE) mode_d = M_IDLE;
          end
          M_IDENT: begin
            if (is_alpha(c) || is_digit(c)) begin
              if (grow_ok1) tlen_d = tlen_q + 7'd1;
              else begin
                fail_v = 1'b1;
                fail_code = ERR_TOO_LONG;
              end
            end else begin
              cand_en[0] = 1'b1;
              fresh = 1'b1;
            end
          end
          M_NUMBER: begin
            if (is_digit(c)) begin
              if (grow_ok1) begin
                tlen_d = tlen_q + 7'd1;
                accum_d = (acc_next[66:63] != 4'd0) ? VAL_MAX : acc_next[62:0];
              end else begin
                fail_v = 1'b1;
                fail_code = ERR_TOO_LONG;
              end
            end else if (c == CH_DOT) begin
              mode_d = M_NUMDOT;
            end else begin
              cand_en[0] = 1'b1;
              cand[0].kind = K_INT;
              cand[0].val = accum_q;
              fresh = 1'b1;
            end
          end
          M_NUMDOT: begin
            if (is_digit(c)) begin
              if (grow_ok2) begin
                tlen_d = tlen_q + 7'd2;
                mode_d = M_FLOAT;
              end else begin
                fail_v = 1'b1;
                fail_code = ERR_TOO_LONG;
              end
            end else begin
              cand_en[0] = 1'b1;
              cand[0].kind = K_INT;
              cand[0].val = accum_q;
              cand_en[1] = 1'b1;
              fresh = 1'b1;
            end
          end
          M_FLOAT: begin
            if (is_digit(c)) begin
              if (grow_ok1) tlen_d = tlen_q + 7'd1;
              else begin
                fail_v = 1'b1;
                fail_code = ERR_TOO_LONG;
              end
            end else begin
              cand_en[0] = 1'b1;
              cand[0].kind = K_FLOAT;
              fresh = 1'b1;
            end
          end
          M_STRING: begin
            if (c == CH_APOS) begin
              cand_en[0] = 1'b1;
              cand[0].kind = K_STRING;
              mode_d = M_IDLE;
            end else if (c == CH_NL) begin
              fail_v = 1'b1;
              fail_code = ERR_NL_STRING;
            end else if (grow_ok1) begin
              tlen_d = tlen_q + 7'd1;
            end else begin
              fail_v = 1'b1;
              fail_code = ERR_TOO_LONG;
            end
          end
          M_LESS: begin
            cand_en[0] = 1'b1;
            if (c == CH_MINUS) begin
              cand[0].kind = K_ARROW;
              cand[0].len = 7'd2;
              mode_d = M_IDLE;
            end else begin
              cand[0].kind = K_LESS;
              cand[0].len = 7'd1;
              fresh = 1'b1;
            end
          end
          default: fresh = 1'b1;
        endcase

        // byte handled from the idle state
        if (fresh) begin
          mode_d = M_IDLE;
          if (c == CH_SPACE || c == CH_TAB || c == CH_NL) begin
            mode_d = M_IDLE;
          end else if (c == CH_QUOTE) begin
            mode_d = M_COMMENT;
          end else if (is_alpha(c) || is_digit(c) || c == CH_APOS || c == CH_LESS) begin
            tso_d = pos_q;
            tsl_d = line_q;
            tsc_d = col_q;
            if (is_alpha(c)) begin
              mode_d = M_IDENT;
              tlen_d = 7'd1;
            end else if (is_digit(c)) begin
              mode_d = M_NUMBER;
              tlen_d = 7'd1;
              accum_d = {59'd0, digit};
            end else if (c == CH_APOS) begin
              mode_d = M_STRING;
              tlen_d = 7'd0;
            end else begin
              mode_d = M_LESS;
              tlen_d = 7'd0;
            end
          end else if (pk.ok) begin
            cand_en[2] = 1'b1;
            cand[2].kind = pk.kind;
            cand[2].len = 7'd1;
          end else begin
            fail_v = 1'b1;
            fail_code = ERR_UNKNOWN;
          end
        end

        // position tracking
        pos_d = pos_q + 24'd1;
        if (c == CH_NL) begin
          if (line_q < LINE_MAX) line_d = line_q + 20'd1;
          col_d = 16'd0;
        end else if (col_q < COL_MAX) begin
          col_d = col_q + 16'd1;
        end
      end

      if (fail_v) begin
        cand_en[2] = 1'b1;
        cand[2].kind = K_ERROR;
        cand[2].len = 7'd0;
        cand[2].err = fail_code;
        halted_d = 1'b1;
      end
    end
  end

  // pack enabled slots in order
  always_comb begin
    n_res = 2'd0;
    for (int i = 0; i < 3; i++) res[i] = '0;
    for (int i = 0; i < 4; i++) begin
      if (cand_en[i] && n_res != 2'd3) begin
        res[n_res] = cand[i];
        n_res = n_res + 2'd1;
      end
    end
    for (int i = 0; i < 3; i++) begin
      res[i].last = (2'(i) == n_res - 2'd1);
    end
  end

  // scanner registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_TOKEN_LEN;
      mode_q    <= M_IDLE;
      tlen_q    <= 7'd0;
      accum_q   <= 63'd0;
      pos_q     <= 24'd0;
      line_q    <= 20'd1;
      col_q     <= 16'd0;
      tso_q     <= 24'd0;
      tsl_q     <= 20'd1;
      tsc_q     <= 16'd0;
      halted_q  <= 1'b0;
    end else begin
      if (cfg_we_i) max_len_q <= cfg_wdata_i;
      mode_q   <= mode_d;
      tlen_q   <= tlen_d;
      accum_q  <= accum_d;
      pos_q    <= pos_d;
      line_q   <= line_d;
      col_q    <= col_d;
      tso_q    <= tso_d;
      tsl_q    <= tsl_d;
      tsc_q    <= tsc_d;
      halted_q <= halted_d;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      count_q  <= 3'd0;
    end else begin
      wr_ptr_q <= wr_ptr_q + n_res;
      if (m_fire) rd_ptr_q <= rd_ptr_q + 2'd1;
      count_q <= count_q + {1'b0, n_res} - {2'd0, m_fire};
    end
  end

  // queue entries
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < n_res) queue_q[wr_ptr_q + 2'(i)] <= res[i];
    end
  end

  // output side
  assign m_axis_tvalid = (count_q != 3'd0);
  assign m_axis_tuser  = queue_q[rd_ptr_q].kind;
  assign m_axis_tlast  = queue_q[rd_ptr_q].last;
  assign m_axis_tdata  = {3'd0,
                          queue_q[rd_ptr_q].err,
                          queue_q[rd_ptr_q].val,
                          queue_q[rd_ptr_q].len,
                          queue_q[rd_ptr_q].col,
                          queue_q[rd_ptr_q].line,
                          queue_q[rd_ptr_q].off};

endmodule

### verif/tb_source_token_lexer.sv
`timescale 1ns / 1ps

module tb_source_token_lexer;
  import stl_pkg::*;

  // '(' is the first punctuation kind, the rest follow the order of punct_set
  localparam logic [4:0] K_LPAREN = 5'd0;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we = 1'b0;
  logic [6:0]   cfg_wdata = '0;
  logic         s_valid = 1'b0;
  logic [7:0]   s_byte = '0;
  logic         s_eoi = 1'b0;
  logic         m_ready = 1'b0;
  logic         s_axis_tready;
  logic         m_axis_tvalid;
  logic [135:0] m_axis_tdata;
  logic [4:0]   m_axis_tuser;
  logic         m_axis_tlast;

  source_token_lexer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_byte),
    .s_axis_tuser  (s_eoi),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // position in this string is the token kind ('<' is scanned on its own)
  string punct_set = "()[]{}|:.+-*/%!~&^=<>";

  // mirror of the lexer state
  logic [3:0]  scan_mode = M_IDLE;
  logic [6:0]  text_len = '0;
  logic [62:0] num_acc = '0;
  logic [23:0] cur_off = '0;
  logic [19:0] cur_line = 20'd1;
  logic [15:0] cur_col = '0;
  logic [23:0] tok_off = '0;
  logic [19:0] tok_line = 20'd1;
  logic [15:0] tok_col = '0;
  logic        halted = 1'b0;
  logic [6:0]  limit_reg = MAX_TOKEN_LEN;

  token_t step_tokens[$];
  token_t expected_tokens[$];

  int mismatch_count = 0;
  int tokens_seen = 0;
  int bytes_sent = 0;
  bit no_idle = 1'b0;

  // directed rows
  string  row_text[$];
  bit     row_typed[$];
  token_t row_want[$];

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #12_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // token scanner mirror
  // ---------------------------------------------------------------------------

  function automatic bit is_letter(input logic [7:0] c);
    return c == "_" || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_decimal(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic int punct_code(input logic [7:0] c);
    for (int i = 0; i < punct_set.len(); i++) begin
      if (i != K_LESS && punct_set[i] == c) return i;
    end
    return -1;
  endfunction

  function automatic bit is_unknown(input logic [7:0] c);
    if (c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_QUOTE) return 1'b0;
    if (c == CH_APOS || c == CH_LESS || is_letter(c) || is_decimal(c)) return 1'b0;
    return punct_code(c) < 0;
  endfunction

  function automatic int eff_limit();
    int v;
    v = int'(limit_reg);
    if (v < 1) v = 1;
    if (v > int'(MAX_TOKEN_LEN)) v = int'(MAX_TOKEN_LEN);
    return v;
  endfunction

  function automatic void add_token(input logic [4:0] kind, input logic [23:0] off,
                                    input logic [19:0] ln, input logic [15:0] cl,
                                    input logic [6:0] len, input logic [62:0] val,
                                    input logic [2:0] err);
    token_t t;
    if (step_tokens.size() >= 3) return;
    t.kind = kind;
    t.off  = off;
    t.line = ln;
    t.col  = cl;
    t.len  = len;
    t.val  = val;
    t.err  = err;
    t.last = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function automatic void raise_error(input logic [2:0] code);
    add_token(K_ERROR, cur_off, cur_line, cur_col, '0, '0, code);
    halted = 1'b1;
  endfunction

  function automatic void emit_pending(input logic [4:0] kind, input logic [62:0] val);
    add_token(kind, tok_off, tok_line, tok_col, text_len, val, ERR_NONE);
  endfunction

  function automatic void open_token(input logic [3:0] mode, input logic [6:0] len);
    scan_mode = mode;
    text_len  = len;
    tok_off   = cur_off;
    tok_line  = cur_line;
    tok_col   = cur_col;
  endfunction

  function automatic bit grow(input int k);
    if (int'(text_len) + k > eff_limit()) begin
      raise_error(ERR_TOO_LONG);
      return 1'b0;
    end
    text_len = text_len + 7'(k);
    return 1'b1;
  endfunction

  // decimal accumulate, saturating at the largest 63-bit value
  function automatic void add_digit(input logic [7:0] c);
    logic [63:0] d, acc, top;
    d   = {56'd0, 8'(c - "0")};
    acc = {1'b0, num_acc};
    top = {1'b0, VAL_MAX};
    if (acc > (top - d) / 64'd10) begin
      num_acc = VAL_MAX;
    end else begin
      num_acc = 63'(acc * 64'd10 + d);
    end
  endfunction

  // int followed by the held dot as a period token
  function automatic void emit_int_dot();
    logic [16:0] c;
    c = {1'b0, tok_col} + 17'(text_len);
    if (c > {1'b0, COL_MAX}) c = {1'b0, COL_MAX};
    emit_pending(K_INT, num_acc);
    add_token(K_PERIOD, tok_off + 24'(text_len), tok_line, c[15:0], 7'd1, '0, ERR_NONE);
  endfunction

  // byte seen between tokens
  function automatic void scan_fresh(input logic [7:0] c);
    int k;
    scan_mode = M_IDLE;
    if (c == CH_SPACE || c == CH_TAB || c == CH_NL) return;
    if (c == CH_QUOTE) begin
      scan_mode = M_COMMENT;
      return;
    end
    if (is_letter(c)) begin
      open_token(M_IDENT, 7'd1);
      return;
    end
    if (is_decimal(c)) begin
      open_token(M_NUMBER, 7'd1);
      num_acc = 63'(c - "0");
      return;
    end
    if (c == CH_APOS) begin
      open_token(M_STRING, 7'd0);
      return;
    end
    if (c == CH_LESS) begin
      open_token(M_LESS, 7'd0);
      return;
    end
    k = punct_code(c);
    if (k < 0) begin
      raise_error(ERR_UNKNOWN);
    end else begin
      add_token(5'(k), cur_off, cur_line, cur_col, 7'd1, '0, ERR_NONE);
    end
  endfunction

  function automatic void advance(input logic [7:0] c);
    cur_off = cur_off + 24'd1;
    if (c == CH_NL) begin
      if (cur_line != LINE_MAX) cur_line = cur_line + 20'd1;
      cur_col = '0;
    end else if (cur_col != COL_MAX) begin
      cur_col = cur_col + 16'd1;
    end
  endfunction

  // tokens caused by one accepted request, left in step_tokens
  function automatic void lex_step(input logic [7:0] b, input logic eoi);
    bit fresh;
    token_t t;
    fresh = 1'b0;
    step_tokens.delete();
    if (halted) return;
    if (eoi) begin
      case (scan_mode)
        M_COMMENT: raise_error(ERR_EOF_COMMENT);
        M_STRING:  raise_error(ERR_EOF_STRING);
        M_IDENT:   emit_pending(K_IDENT, '0);
        M_NUMBER:  emit_pending(K_INT, num_acc);
        M_NUMDOT:  emit_int_dot();
        M_FLOAT:   emit_pending(K_FLOAT, '0);
        M_LESS:    add_token(K_LESS, tok_off, tok_line, tok_col, 7'd1, '0, ERR_NONE);
        default:   ;
      endcase
      if (!halted) add_token(K_END, cur_off, cur_line, cur_col, '0, '0, ERR_NONE);
      halted = 1'b1;
      scan_mode = M_DONE;
    end else begin
      case (scan_mode)
        M_COMMENT: begin
          if (b == CH_QUOTE) scan_mode = M_IDLE;
        end
        M_IDENT: begin
          if (is_letter(b) || is_decimal(b)) begin
            void'(grow(1));
          end else begin
            emit_pending(K_IDENT, '0);
            fresh = 1'b1;
          end
        end
        M_NUMBER: begin
          if (is_decimal(b)) begin
            if (grow(1)) add_digit(b);
          end else if (b == CH_DOT) begin
            scan_mode = M_NUMDOT;
          end else begin
            emit_pending(K_INT, num_acc);
            fresh = 1'b1;
          end
        end
        M_NUMDOT: begin
          if (is_decimal(b)) begin
            if (grow(2)) scan_mode = M_FLOAT;
          end else begin
            emit_int_dot();
            fresh = 1'b1;
          end
        end
        M_FLOAT: begin
          if (is_decimal(b)) begin
            void'(grow(1));
          end else begin
            emit_pending(K_FLOAT, '0);
            fresh = 1'b1;
          end
        end
        M_STRING: begin
          if (b == CH_APOS) begin
            emit_pending(K_STRING, '0);
            scan_mode = M_IDLE;
          end else if (b == CH_NL) begin
            raise_error(ERR_NL_STRING);
          end else begin
            void'(grow(1));
          end
        end
        M_LESS: begin
          if (b == CH_MINUS) begin
            add_token(K_ARROW, tok_off, tok_line, tok_col, 7'd2, '0, ERR_NONE);
            scan_mode = M_IDLE;
          end else begin
            add_token(K_LESS, tok_off, tok_line, tok_col, 7'd1, '0, ERR_NONE);
            fresh = 1'b1;
          end
        end
        default: fresh = 1'b1;
      endcase
      if (fresh && !halted) scan_fresh(b);
      advance(b);
    end
    if (step_tokens.size() > 0) begin
      t = step_tokens.pop_back();
      t.last = 1'b1;
      step_tokens.push_back(t);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 200) $display("mismatch: %s", msg);
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("token %0d %s: got %0h, want %0h",
                                tokens_seen, name, got, want));
    end
  endtask

  task automatic check_token();
    token_t want;
    tokens_seen++;
    if (expected_tokens.size() == 0) begin
      report_mismatch($sformatf("token %0d: kind %0d arrived with nothing expected",
                                tokens_seen, m_axis_tuser));
      return;
    end
    want = expected_tokens.pop_front();
    compare_field("kind", m_axis_tuser, want.kind);
    compare_field("offset", m_axis_tdata[23:0], want.off);
    compare_field("line", m_axis_tdata[43:24], want.line);
    compare_field("column", m_axis_tdata[59:44], want.col);
    compare_field("length", m_axis_tdata[66:60], want.len);
    compare_field("value", m_axis_tdata[129:67], want.val);
    compare_field("error", m_axis_tdata[132:130], want.err);
    compare_field("pad", m_axis_tdata[135:133], '0);
    compare_field("last", m_axis_tlast, want.last);
  endtask

  function automatic int draw_gap();
    return no_idle ? 0 : int'($urandom_range(0, 17));
  endfunction

  // token sink with random stalls
  initial begin
    int gap;
    wait (rst_ni === 1'b1);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      check_token();
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  task automatic send_item(input logic [7:0] b, input logic eoi);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_byte  <= b;
    s_eoi   <= eoi;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    bytes_sent++;
    lex_step(b, eoi);
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endtask

  task automatic send_text(input string s);
    for (int j = 0; j < s.len(); j++) send_item(s[j], 1'b0);
  endtask

  task automatic wait_for_tokens();
    while (expected_tokens.size() != 0) @(posedge clk_i);
  endtask

  // register write with the input side quiet and all tokens delivered
  task automatic write_limit(input logic [6:0] v);
    s_valid <= 1'b0;
    wait_for_tokens();
    repeat (4) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    limit_reg = v;
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return "_";
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  // mostly short, sometimes exactly at the upper bound
  function automatic int pick_len(input int lo, input int hi);
    if ($urandom_range(0, 7) == 0) return hi;
    return $urandom_range(lo, (hi < lo + 5) ? hi : lo + 5);
  endfunction

  function automatic logic [7:0] rand_punct();
    return punct_set[$urandom_range(0, punct_set.len() - 1)];
  endfunction

  task automatic send_separator();
    logic [7:0] p;
    case ($urandom_range(0, 5))
      0: send_item(CH_SPACE, 1'b0);
      1: send_item(CH_TAB, 1'b0);
      2: send_item(CH_NL, 1'b0);
      default: begin
        do p = rand_punct(); while (p == CH_DOT);
        send_item(p, 1'b0);
      end
    endcase
  endtask

  task automatic send_digits(input int n);
    repeat (n) send_item(rand_digit(), 1'b0);
  endtask

  // one well-formed token or a bit of noise, never leaving a number open
  task automatic send_fragment();
    int lim, n, a, pick;
    logic [7:0] b;
    lim = eff_limit();
    pick = $urandom_range(0, 99);
    if (pick < 16) begin
      // identifier
      n = pick_len(1, lim);
      send_item(rand_letter(), 1'b0);
      repeat (n - 1) send_item(($urandom_range(0, 2) == 0) ? rand_digit() : rand_letter(), 1'b0);
      send_separator();
    end else if (pick < 30) begin
      // integer, sometimes near or past saturation
      if (lim >= 20 && $urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: send_text("9223372036854775807");
          1: send_text("9223372036854775808");
          default: begin
            repeat ($urandom_range(19, 20)) begin
              send_item(($urandom_range(0, 3) == 0) ? rand_digit() : 8'("9"), 1'b0);
            end
          end
        endcase
      end else begin
        send_digits(pick_len(1, lim));
      end
      send_separator();
    end else if (pick < 40 && lim >= 3) begin
      // float, sometimes closed by a period
      a = pick_len(1, lim - 2);
      send_digits(a);
      send_item(CH_DOT, 1'b0);
      send_digits(pick_len(1, lim - 1 - a));
      if ($urandom_range(0, 2) == 0) send_item(CH_DOT, 1'b0);
      send_separator();
    end else if (pick < 48) begin
      // digits, dot, then no digit
      send_digits(pick_len(1, lim));
      send_item(CH_DOT, 1'b0);
      if ($urandom_range(0, 1) == 0) send_item(rand_letter(), 1'b0);
      send_separator();
    end else if (pick < 60) begin
      // quoted string with any byte but apostrophe or newline inside
      n = pick_len(0, lim);
      send_item(CH_APOS, 1'b0);
      repeat (n) begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_APOS || b == CH_NL);
        send_item(b, 1'b0);
      end
      send_item(CH_APOS, 1'b0);
    end else if (pick < 66) begin
      // comment with any byte but a double quote inside
      send_item(CH_QUOTE, 1'b0);
      repeat ($urandom_range(0, 10)) begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
        send_item(b, 1'b0);
      end
      send_item(CH_QUOTE, 1'b0);
    end else if (pick < 86) begin
      // punctuation burst, arrows included
      repeat ($urandom_range(1, 3)) begin
        b = rand_punct();
        send_item(b, 1'b0);
        if (b == CH_LESS && $urandom_range(0, 1) == 0) send_item(CH_MINUS, 1'b0);
      end
    end else begin
      // whitespace run
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 2))
          0: send_item(CH_SPACE, 1'b0);
          1: send_item(CH_TAB, 1'b0);
          default: send_item(CH_NL, 1'b0);
        endcase
      end
    end
  endtask

  // closing request: end of input in some scan mode, or one of the errors
  task automatic send_closing();
    logic [7:0] b;
    send_item(CH_SPACE, 1'b0);
    case ($urandom_range(0, 10))
      1:  send_text("ab");
      2:  send_text("42");
      3:  send_text("42.");
      4:  send_text("4.2");
      5:  send_item(CH_LESS, 1'b0);
      6:  send_text("\"abc");
      7:  send_text("'ab");
      8: begin
        case ($urandom_range(0, 2))
          0: b = 8'h00;
          1: b = 8'h0D;
          default: begin
            do b = 8'($urandom_range(0, 255)); while (!is_unknown(b));
          end
        endcase
        send_item(b, 1'b0);
      end
      9: begin
        send_item(rand_letter(), 1'b0);
        repeat (eff_limit()) send_item(rand_letter(), 1'b0);
      end
      10: send_text("'a\n");
      default: ;
    endcase
    send_item(8'($urandom_range(0, 255)), 1'b1);
    // all of these are swallowed by the halted block
    repeat (8) send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  function automatic token_t mk_token(input logic [4:0] kind, input logic [23:0] off,
                                      input logic [19:0] ln, input logic [15:0] cl,
                                      input logic [6:0] len);
    token_t t;
    t.kind = kind;
    t.off  = off;
    t.line = ln;
    t.col  = cl;
    t.len  = len;
    t.val  = '0;
    t.err  = ERR_NONE;
    t.last = 1'b1;
    return t;
  endfunction

  task automatic add_row(input string text, input bit typed, input token_t want);
    row_text.push_back(text);
    row_typed.push_back(typed);
    row_want.push_back(want);
  endtask

  initial begin
    logic [6:0] phase_limits[$];
    int phase_start;

    // directed rows, the typed ones each end in exactly one token
    add_row("(", 1'b1, mk_token(K_LPAREN, 24'd0, 20'd1, 16'd0, 7'd1));
    add_row("<-", 1'b1, mk_token(K_ARROW, 24'd1, 20'd1, 16'd1, 7'd2));
    add_row("\"\377\"", 1'b0, '0);
    add_row("''", 1'b1, mk_token(K_STRING, 24'd6, 20'd1, 16'd6, 7'd0));
    add_row("7.\t", 1'b0, '0);
    add_row("1.5.", 1'b0, '0);
    add_row("<x\n", 1'b0, '0);
    add_row("a9_|", 1'b0, '0);

    phase_limits = '{7'd1, 7'd0, 7'd127, 7'd64, 7'd2, 7'd3, 7'd40};
    phase_limits[5] = 7'($urandom_range(3, 63));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (row_text[i]) begin
      send_text(row_text[i]);
      if (row_typed[i]) begin
        repeat (step_tokens.size()) void'(expected_tokens.pop_back());
        expected_tokens.push_back(row_want[i]);
      end
    end

    // random phases, each under its own length limit
    foreach (phase_limits[p]) begin
      write_limit(phase_limits[p]);
      no_idle = (p == 3);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 50) send_fragment();
    end
    no_idle = 1'b0;

    send_closing();

    s_valid <= 1'b0;
    wait_for_tokens();
    repeat (24) @(posedge clk_i);
    if (expected_tokens.size() != 0) begin
      report_mismatch($sformatf("%0d tokens never arrived", expected_tokens.size()));
    end
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### source_token_lexer.f
sv/stl_pkg.sv
sv/source_token_lexer.sv
verif/tb_source_token_lexer.sv
